>>> src/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; the including module must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define SDIV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when trig holds, cons holds at the next edge.
`define SDIV_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sdiv_pkg.sv
// Shared width, constants and the cell-to-cell beat type of the divider.
// No dependencies.
package sdiv_pkg;

  localparam int DATA_WIDTH = 32;

  localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};

  // One item as it walks down the row of cells.
  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] rem;   // partial remainder
    logic [DATA_WIDTH-1:0] nq;    // dividend bits above, quotient bits shifted in below
    logic [DATA_WIDTH-1:0] den;   // divisor magnitude
    logic                  neg;
    logic                  sat;
    logic                  dz;
  } sdiv_beat_t;

endpackage

>>> src/sdiv_cell.sv
// One restoring shift-subtract step with its output register.
// Depends on sdiv_pkg.
module sdiv_cell
  import sdiv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  sdiv_beat_t beat_in,
  output sdiv_beat_t beat_out
);

  sdiv_beat_t            beat_r;
  sdiv_beat_t            beat_nxt;
  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  ge;

  // rem < den <= 2^(W-1), so the shifted remainder still fits in W bits
  assign trial = {beat_in.rem[DATA_WIDTH-2:0], beat_in.nq[DATA_WIDTH-1]};
  assign diff  = {1'b0, trial} - {1'b0, beat_in.den};
  assign ge    = ~diff[DATA_WIDTH];

  always_comb begin
    beat_nxt     = beat_in;
    beat_nxt.rem = ge ? diff[DATA_WIDTH-1:0] : trial;
    beat_nxt.nq  = {beat_in.nq[DATA_WIDTH-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.valid <= 1'b0;
    end else if (en) begin
      beat_r.valid <= beat_nxt.valid;
    end
    if (en) begin
      beat_r.rem <= beat_nxt.rem;
      beat_r.nq  <= beat_nxt.nq;
      beat_r.den <= beat_nxt.den;
      beat_r.neg <= beat_nxt.neg;
      beat_r.sat <= beat_nxt.sat;
      beat_r.dz  <= beat_nxt.dz;
    end
  end

  assign beat_out = beat_r;

endmodule

>>> src/signed_integer_divider_top.sv
// Top level of the signed divider: operand prep, a row of step cells, sign fix and output register.
// Depends on sdiv_pkg and sdiv_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries in_dividend and in_divisor (signed).
//   Result channel out_valid/out_ready carries out_quotient (truncated toward
//   zero), out_saturated (INT_MIN / -1 clamped to INT_MAX) and out_divide_by_zero
//   (divisor zero, quotient 0).
//   One item is in flight at a time. An accepted item passes through DATA_WIDTH
//   cells, one quotient bit per cell per cycle while the row is not held, then
//   loads the output register. in_ready returns at the same edge that sets
//   out_valid, so a new item is not taken before the last one has left the
//   cell row.
//   The next item is taken while a finished result still waits in the output
//   register. If the receiver stalls, a later result parks in the last cell and
//   the row holds until the output register frees.
//   Reset (rst_n low, synchronous) clears the busy flag, the cell valid bits
//   and out_valid; no item survives it.
module signed_integer_divider_top
  import sdiv_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic                         out_saturated,
  output logic                         out_divide_by_zero
);

  logic                  busy_r;
  logic                  busy_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [DATA_WIDTH-1:0] quot_r;
  logic [DATA_WIDTH-1:0] quot_nxt;
  logic                  sat_r;
  logic                  dz_r;
  logic                  accept;
  logic                  load;
  logic                  en;
  sdiv_beat_t            head;
  sdiv_beat_t            row [DATA_WIDTH];
  sdiv_beat_t            tail;

  assign accept = in_valid & in_ready;
  assign in_ready = ~busy_r;

  always_comb begin
    head.valid = accept;
    head.rem   = '0;
    head.nq    = in_dividend[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - in_dividend) : in_dividend;
    head.den   = in_divisor[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - in_divisor) : in_divisor;
    head.neg   = in_dividend[DATA_WIDTH-1] ^ in_divisor[DATA_WIDTH-1];
    head.dz    = (in_divisor == '0);
    head.sat   = (in_dividend == INT_MIN) && (in_divisor == MINUS_ONE);
  end

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    sdiv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .beat_in ((i == 0) ? head : row[(i == 0) ? 0 : i-1]),
      .beat_out(row[i])
    );
  end

  assign tail = row[DATA_WIDTH-1];

  // hold the row while a finished item waits on a full output register
  assign load = tail.valid & (~out_valid_r | out_ready);
  assign en   = ~(tail.valid & ~load);

  always_comb begin
    if (tail.dz) begin
      quot_nxt = '0;
    end else if (tail.sat) begin
      quot_nxt = INT_MAX;
    end else if (tail.neg) begin
      quot_nxt = DATA_WIDTH'(0) - tail.nq;
    end else begin
      quot_nxt = tail.nq;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (load) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quot_r <= quot_nxt;
      sat_r  <= tail.sat & ~tail.dz;
      dz_r   <= tail.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_quotient       = quot_r;
  assign out_saturated      = sat_r;
  assign out_divide_by_zero = dz_r;

endmodule

>>> src/sdiv_checker.sv
// Port-level checks on the divider top, attached by bind.
// Depends on sdiv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdiv_assertions
  import sdiv_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] out_quotient,
  input logic                  out_saturated,
  input logic                  out_divide_by_zero
);

  `SDIV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_quotient), "result beat dropped or changed while stalled")
  `SDIV_ASSERT(a_flags_excl, !(out_valid && out_saturated && out_divide_by_zero), "both flags set")
  `SDIV_ASSERT(a_dz_zero, !(out_valid && out_divide_by_zero) || (out_quotient == '0), "divide by zero with nonzero quotient")
  `SDIV_ASSERT(a_sat_max, !(out_valid && out_saturated) || (out_quotient == INT_MAX), "saturated quotient not INT_MAX")
  `SDIV_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second beat taken while busy")

endmodule

bind signed_integer_divider_top sdiv_assertions u_sdiv_assertions (.*);
